// ----- hdl/ssf_pkg.sv -----
// ----------------------------------------------------------------------------
// ssf_pkg
// Shared types and constants for the sunrise / sunset fade controller.
// ----------------------------------------------------------------------------
package ssf_pkg;

    localparam int SECONDS_PER_DAY_DEF = 86400;

    localparam int TPS_W    = 8;   // ticks per second, tick counter
    localparam int SEC_W    = 17;  // second of day
    localparam int LEVEL_W  = 8;   // lamp level
    localparam int MODE_W   = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 17;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_SECOND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAKEUP_SECOND    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAKE_WINDOW      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDDOWN_SECOND  = 2'd3;

    // register reset values
    localparam logic [TPS_W-1:0] TPS_RST      = 8'd64;
    localparam logic [SEC_W-1:0] WAKEUP_RST   = 17'd21600;
    localparam logic [SEC_W-1:0] WINDOW_RST   = 17'd500;
    localparam logic [SEC_W-1:0] WINDDOWN_RST = 17'd79200;

    // state reset values
    localparam logic [SEC_W-1:0] DAY_SEC_RST = 17'd79200;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;
    localparam logic [LEVEL_W-1:0] LEVEL_MIN = 8'd0;

    // mode codes
    localparam logic [MODE_W-1:0] MODE_NIGHT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WAKE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DAY   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_WIND  = 2'd3;

    typedef struct packed {
        logic [SEC_W-1:0] wakeup_second;
        logic [SEC_W-1:0] wake_window;
        logic [SEC_W-1:0] winddown_second;
    } t_sched_cfg;

    typedef struct packed {
        logic             advanced;
        logic [SEC_W-1:0] second;
    } t_time;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               lamp_on;
        logic [MODE_W-1:0]  mode;
    } t_light;

endpackage

// ----- hdl/ssf_timekeeper.sv -----
// ----------------------------------------------------------------------------
// ssf_timekeeper
// Counts slow ticks into seconds and keeps the wrapping second of day.
// ----------------------------------------------------------------------------
module ssf_timekeeper
    import ssf_pkg::*;
#(
    parameter int SECONDS_PER_DAY = SECONDS_PER_DAY_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic             i_tick,
    input  logic [TPS_W-1:0] i_ticks_per_second,
    output t_time            o_time
);

    localparam logic [SEC_W:0] DAY_LEN = (SEC_W+1)'(SECONDS_PER_DAY);

    logic [TPS_W-1:0] r_tick_count, n_tick_count;
    logic [SEC_W-1:0] r_day_seconds, n_day_seconds;
    logic [TPS_W:0]   w_cnt;
    logic [SEC_W:0]   w_sec_inc;
    logic             w_adv;

    always_comb begin
        w_cnt        = {1'b0, r_tick_count} + 1'b1;
        w_sec_inc    = {1'b0, r_day_seconds} + 1'b1;
        w_adv        = 1'b0;
        n_tick_count = r_tick_count;
        if (i_tick) begin
            // zero ticks per second falls out as "every tick"
            if (w_cnt >= {1'b0, i_ticks_per_second}) begin
                n_tick_count = '0;
                w_adv        = 1'b1;
            end else begin
                n_tick_count = w_cnt[TPS_W-1:0];
            end
        end
        n_day_seconds = r_day_seconds;
        if (w_adv) begin
            n_day_seconds = (w_sec_inc >= DAY_LEN) ? '0 : w_sec_inc[SEC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_count  <= '0;
            r_day_seconds <= DAY_SEC_RST;
        end else if (i_step) begin
            r_tick_count  <= n_tick_count;
            r_day_seconds <= n_day_seconds;
        end
    end

    assign o_time.advanced = w_adv;
    assign o_time.second   = n_day_seconds;

endmodule

// ----- hdl/ssf_mode_fsm.sv -----
// ----------------------------------------------------------------------------
// ssf_mode_fsm
// Night / wake-up / day / wind-down sequencer with the brightness ramp.
// ----------------------------------------------------------------------------
module ssf_mode_fsm
    import ssf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  t_time      i_time,
    input  t_sched_cfg i_cfg,
    output t_light     o_light
);

    logic [MODE_W-1:0]  r_mode, n_mode;
    logic [LEVEL_W-1:0] r_brightness, n_brightness;
    logic [SEC_W:0]     w_window_end;
    logic               w_in_window;

    // window end taken without wrapping, hence the extra bit
    assign w_window_end = {1'b0, i_cfg.wakeup_second} + {1'b0, i_cfg.wake_window};
    assign w_in_window  = (i_time.second >= i_cfg.wakeup_second) &&
                          ({1'b0, i_time.second} < w_window_end);

    always_comb begin
        n_mode       = r_mode;
        n_brightness = r_brightness;
        case (r_mode)
            MODE_NIGHT: begin
                if (w_in_window) begin
                    n_mode       = MODE_WAKE;
                    n_brightness = LEVEL_MIN;
                end
            end
            MODE_WAKE: begin
                if (i_time.advanced && r_brightness != LEVEL_MAX) begin
                    n_brightness = r_brightness + 1'b1;
                end
                if (n_brightness == LEVEL_MAX) begin
                    n_mode = MODE_DAY;
                end
            end
            MODE_DAY: begin
                if (i_time.second >= i_cfg.winddown_second) begin
                    n_mode       = MODE_WIND;
                    n_brightness = LEVEL_MAX;
                end
            end
            default: begin
                if (i_time.advanced && r_brightness != LEVEL_MIN) begin
                    n_brightness = r_brightness - 1'b1;
                end
                if (n_brightness == LEVEL_MIN) begin
                    n_mode = MODE_NIGHT;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_DAY;
            r_brightness <= LEVEL_MIN;
        end else if (i_step) begin
            r_mode       <= n_mode;
            r_brightness <= n_brightness;
        end
    end

    assign o_light.level   = n_brightness;
    assign o_light.lamp_on = (n_mode == MODE_WAKE) || (n_mode == MODE_WIND);
    assign o_light.mode    = n_mode;

endmodule

// ----- hdl/sunrise_sunset_fade_controller.sv -----
// ----------------------------------------------------------------------------
// sunrise_sunset_fade_controller
// Time-of-day lamp fader driven by a slow timer tick.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one word per timer event:
//   i_tick = 1 counts a slow tick, 0 only re-evaluates the mode.
//   Output channel (o_out_valid / i_out_stall) returns one word per input
//   word: lamp level, lamp enable, mode and second of day after the update.
//   Config port: i_cfg_we / i_cfg_index / i_cfg_data, write only, to be
//   used while no words are in flight.
// Timing:
//   A word accepted into the input register goes through the update logic
//   into the result register as soon as that register is free or being
//   taken, and o_out_valid then rises. One word per cycle is sustained while
//   i_out_stall is low; the counter/mode update is a single short path, so
//   every such cycle can take a word.
// Reset (synchronous, active low): registers return to defaults, time is
//   79200 s, mode is day, level 0, both pipeline slots empty.
// Stall: a stalled output word holds; the input register keeps taking one
//   more word, after which o_in_stall follows i_out_stall.
// ----------------------------------------------------------------------------
module sunrise_sunset_fade_controller
    import ssf_pkg::*;
#(
    parameter int SECONDS_PER_DAY = SECONDS_PER_DAY_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input words
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_tick,
    // output words
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [LEVEL_W-1:0]   o_level,
    output logic                 o_lamp_on,
    output logic [MODE_W-1:0]    o_mode_now,
    output logic [SEC_W-1:0]     o_second_of_day,
    // configuration
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    // config registers
    logic [TPS_W-1:0] r_ticks_per_second;
    t_sched_cfg       r_sched;

    // input slot
    logic r_in_valid;
    logic r_in_tick;

    // result slot
    logic               r_out_valid;
    logic [LEVEL_W-1:0] r_level;
    logic               r_lamp_on;
    logic [MODE_W-1:0]  r_mode_now;
    logic [SEC_W-1:0]   r_second;

    logic   w_accept;
    logic   w_move;    // input slot word goes through the update this cycle
    t_time  w_time;
    t_light w_light;

    assign w_move     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_move;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks_per_second      <= TPS_RST;
            r_sched.wakeup_second   <= WAKEUP_RST;
            r_sched.wake_window     <= WINDOW_RST;
            r_sched.winddown_second <= WINDDOWN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TICKS_PER_SECOND: r_ticks_per_second      <= i_cfg_data[TPS_W-1:0];
                CFG_WAKEUP_SECOND:    r_sched.wakeup_second   <= i_cfg_data[SEC_W-1:0];
                CFG_WAKE_WINDOW:      r_sched.wake_window     <= i_cfg_data[SEC_W-1:0];
                CFG_WINDDOWN_SECOND:  r_sched.winddown_second <= i_cfg_data[SEC_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_move) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_tick <= i_tick;
        end
    end

    // state advances exactly once per word, when it leaves the input slot
    ssf_timekeeper #(
        .SECONDS_PER_DAY (SECONDS_PER_DAY)
    ) u_time (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_step             (w_move),
        .i_tick             (r_in_tick),
        .i_ticks_per_second (r_ticks_per_second),
        .o_time             (w_time)
    );

    ssf_mode_fsm u_mode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_move),
        .i_time  (w_time),
        .i_cfg   (r_sched),
        .o_light (w_light)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_move) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_level    <= w_light.level;
            r_lamp_on  <= w_light.lamp_on;
            r_mode_now <= w_light.mode;
            r_second   <= w_time.second;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_level         = r_level;
    assign o_lamp_on       = r_lamp_on;
    assign o_mode_now      = r_mode_now;
    assign o_second_of_day = r_second;

endmodule

// ----- hdl/ssf_checker.sv -----
// ----------------------------------------------------------------------------
// ssf_checker
// Port-level checks for the fade controller, bound to the top level.
// ----------------------------------------------------------------------------
module ssf_checker
    import ssf_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [LEVEL_W-1:0] o_level,
    input logic               o_lamp_on,
    input logic [MODE_W-1:0]  o_mode_now,
    input logic [SEC_W-1:0]   o_second_of_day
);

    // stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_level) &&
        $stable(o_lamp_on) && $stable(o_mode_now) && $stable(o_second_of_day))
        else $error("output word changed under stall");

    // lamp enable tracks the ramp modes
    a_lamp_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_lamp_on == ((o_mode_now == MODE_WAKE) ||
                                      (o_mode_now == MODE_WIND)))
        else $error("lamp enable disagrees with mode");

    // night is only reached after the dimming ramp has bottomed out
    a_night_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_mode_now == MODE_NIGHT |-> o_level == LEVEL_MIN)
        else $error("lamp level nonzero in night mode");

    // wake-up hands over to day as soon as full level is held
    a_wake_below_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_mode_now == MODE_WAKE |-> o_level != LEVEL_MAX)
        else $error("wake-up mode at full level");

    // output slot empties on reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind sunrise_sunset_fade_controller ssf_checker u_ssf_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_level         (o_level),
    .o_lamp_on       (o_lamp_on),
    .o_mode_now      (o_mode_now),
    .o_second_of_day (o_second_of_day)
);
